FILE: hw/rtl/swfld_pkg.sv
package swfld_pkg;

   // Bytes in one start or end signature.
   localparam int unsigned WordBytes = 4;

   // Widths of the fields and registers.
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned WordWidth   = WordBytes * ByteWidth;
   localparam int unsigned LengthWidth = 16;
   localparam int unsigned CountWidth  = $clog2(WordBytes);
   localparam int unsigned CsrAddrWidth = 2;

   // Configuration register indexes.
   localparam logic [CsrAddrWidth-1:0] CSR_START_WORD     = 2'd0;
   localparam logic [CsrAddrWidth-1:0] CSR_END_WORD       = 2'd1;
   localparam logic [CsrAddrWidth-1:0] CSR_PAYLOAD_LENGTH = 2'd2;

   // Result kinds.
   localparam logic KIND_PAYLOAD   = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   // One result item.
   typedef struct packed {
      logic                 frame_ok;
      logic                 kind;
      logic [ByteWidth-1:0] out_byte;
   } result_type;

endpackage

FILE: hw/rtl/sync_word_fixed_length_deframer_unit.sv
// Channel | Ports          | Contents
// --------+----------------+--------------------------------------------------
// input   | req_t*         | tdata[7:0] data_byte
// result  | rsp_t*         | tdata[7:0] out_byte; tuser[0] kind, tuser[1] frame_ok
// config  | csr_*          | csr_addr 0 start_word, 1 end_word, 2 payload_length
//
// Each byte is handled in the cycle in which it is transferred: the next mode,
// word gathering state and any result are all worked out combinationally and
// registered at that edge, so one byte is taken every cycle while the input is
// not held off, and any result is written to the result register at that edge.
// The input is held off only while the result register is full and the result
// side is stalling; a byte that gives no result is held off then as well.
// Reset is synchronous and returns the block to hunting with an empty word and
// the registers at start_word 0, end_word 0 and payload_length 1.
module sync_word_fixed_length_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [1:0]  rsp_tuser,   // [0] kind, [1] frame_ok
   // Configuration writes.
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   typedef enum logic [1:0] {
      MODE_HUNT    = 2'd0,
      MODE_PAYLOAD = 2'd1,
      MODE_END     = 2'd2
   } mode_type;

   localparam int unsigned PartialWidth = swfld_pkg::WordWidth - swfld_pkg::ByteWidth;

   // Configuration registers.
   logic [swfld_pkg::WordWidth-1:0]   start_word_ff;
   logic [swfld_pkg::WordWidth-1:0]   end_word_ff;
   logic [swfld_pkg::LengthWidth-1:0] payload_length_ff;

   // Deframing state.
   mode_type                           mode_ff, mode_in;
   logic [PartialWidth-1:0]            partial_ff, partial_in;
   logic [swfld_pkg::CountWidth-1:0]   bytes_ff, bytes_in;
   logic [swfld_pkg::LengthWidth-1:0]  count_ff, count_in;

   // Result register.
   logic                   rsp_valid_ff;
   swfld_pkg::result_type  result_ff, result_in;
   logic                   result_load;

   logic                            req_fire;
   logic [swfld_pkg::ByteWidth-1:0] data_byte;
   logic                            word_done;
   logic [swfld_pkg::WordWidth-1:0] word;
   logic [PartialWidth-1:0]         partial_add;
   logic [swfld_pkg::LengthWidth-1:0] count_next;

   // A byte may enter whenever the result register is empty or being emptied.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign data_byte  = req_tdata;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = result_ff.out_byte;
   assign rsp_tuser  = {result_ff.frame_ok, result_ff.kind};

   // Word gathering: the fourth byte completes the word, little-endian.
   assign word_done  = (bytes_ff == swfld_pkg::CountWidth'(swfld_pkg::WordBytes - 1));
   assign word       = {data_byte, partial_ff};
   assign partial_add = PartialWidth'(data_byte) << (swfld_pkg::ByteWidth * bytes_ff);
   assign count_next = count_ff + 1'b1;

   always_comb begin
      mode_in     = mode_ff;
      partial_in  = partial_ff;
      bytes_in    = bytes_ff;
      count_in    = count_ff;
      result_load = 1'b0;
      result_in   = '0;
      case (mode_ff)
         MODE_PAYLOAD: begin
            // Every payload byte passes straight through.
            count_in           = count_next;
            result_load        = 1'b1;
            result_in.out_byte = data_byte;
            result_in.kind     = swfld_pkg::KIND_PAYLOAD;
            if (count_next == payload_length_ff) begin
               mode_in    = MODE_END;
               partial_in = '0;
               bytes_in   = '0;
            end
         end
         MODE_END: begin
            if (word_done) begin
               partial_in         = '0;
               bytes_in           = '0;
               mode_in            = MODE_HUNT;
               count_in           = '0;
               result_load        = 1'b1;
               result_in.kind     = swfld_pkg::KIND_FRAME_END;
               result_in.frame_ok = (word == end_word_ff);
            end else begin
               partial_in = partial_ff | partial_add;
               bytes_in   = bytes_ff + 1'b1;
            end
         end
         default: begin
            // Hunting, and the unused mode code, which behaves the same.
            mode_in = MODE_HUNT;
            if (word_done) begin
               partial_in = '0;
               bytes_in   = '0;
               if (word == start_word_ff) begin
                  mode_in  = MODE_PAYLOAD;
                  count_in = '0;
               end
            end else begin
               partial_in = partial_ff | partial_add;
               bytes_in   = bytes_ff + 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_word_ff     <= '0;
         end_word_ff       <= '0;
         payload_length_ff <= swfld_pkg::LengthWidth'(1);
         mode_ff           <= MODE_HUNT;
         partial_ff        <= '0;
         bytes_ff          <= '0;
         count_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         // Writes to an index beyond the register list are ignored.
         if (csr_we) begin
            case (csr_addr)
               swfld_pkg::CSR_START_WORD:     start_word_ff <= csr_wdata;
               swfld_pkg::CSR_END_WORD:       end_word_ff   <= csr_wdata;
               swfld_pkg::CSR_PAYLOAD_LENGTH:
                  payload_length_ff <= csr_wdata[swfld_pkg::LengthWidth-1:0];
               default: ;
            endcase
         end
         if (req_fire) begin
            mode_ff    <= mode_in;
            partial_ff <= partial_in;
            bytes_ff   <= bytes_in;
            count_ff   <= count_in;
         end
         if (req_fire && result_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // The result payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_fire && result_load) begin
         result_ff <= result_in;
      end
   end

   // A byte taken while hunting never produces a result.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && mode_ff != MODE_PAYLOAD && mode_ff != MODE_END) |-> !result_load)
      else $error("result produced while hunting");

   // A frame end is only reported on the byte that completes the end word.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && result_load && result_in.kind == swfld_pkg::KIND_FRAME_END)
      |-> (mode_ff == MODE_END && word_done))
      else $error("frame end without a complete end word");

   // An empty word buffer holds no stale bytes.
   assert property (@(posedge clock) disable iff (reset)
      (bytes_ff == '0) |-> (partial_ff == '0))
      else $error("stale bytes in empty word buffer");

   // The payload counter is idle outside a frame.
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_HUNT) |-> (count_ff == '0))
      else $error("payload count not cleared while hunting");

   // A result that was not taken is still offered in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(result_ff)))
      else $error("stalled result lost");

endmodule
